/* src/ray_box_nearest_hit_core_macros.svh */
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_core_macros
// Assertion macros used by the block's sequencer (rbh_ctrl).
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_NEAREST_HIT_CORE_MACROS_SVH
`define RAY_BOX_NEAREST_HIT_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define RBH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the clock edge after the antecedent.
`define RBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rbh_pkg.sv */
// ----------------------------------------------------------------------------
// rbh_pkg
// Shared types for the ray / box nearest hit block.
// ----------------------------------------------------------------------------
package rbh_pkg;

    localparam int unsigned IN_DATA_W  = 256;
    localparam int unsigned OUT_DATA_W = 163;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_ray;     // capture the ray, clear the best hit
        logic load_box;     // capture box bounds and entity
        logic div_start;    // start one division
        logic div_second;   // 0: minimum bound, 1: maximum bound
        logic axis_finish;  // fold the axis result into tmin/tmax
        logic box_finish;   // update the best hit
        logic mul_start;    // start one hit point product
        logic mul_store;    // store one hit point coordinate
        logic emit;         // load the output register
        logic [1:0] axis;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic axis_skip;    // zero direction on this axis
        logic axis_miss;    // containment miss on this axis
        logic slab_miss;    // tmin beyond tmax
    } t_status;

endpackage

/* src/ray_box_nearest_hit_core.sv */
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_core
// Nearest ray / axis-aligned box hit, slab method, fixed point.
// ----------------------------------------------------------------------------
// Input stream: tuser = kind (0 ray, 1 box), tlast = final box, tdata holds
// vec_a_x/y/z, vec_b_x/y/z, ray_limit, body_id. In a box transaction each axis
// with a nonzero direction, up to a containment miss on a zero-direction axis,
// runs two divisions on one shared radix-2 divider, one quotient bit per cycle.
// A final box then computes the hit point (one multiplier, three coordinates)
// and loads the output register.
// Output stream: one transaction per final box, held in an output register;
// tuser = hit, tdata = hit_body, hit_distance, point_x/y/z, normal_axis,
// normal_negative. While the receiver stalls, the result is held; input keeps
// being accepted until the next final box, which waits before loading the output
// register until the held result is taken; no input is accepted meanwhile.
// Reset (synchronous, active low) clears the ray, the best hit and the
// output valid.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_core #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, ray_limit, body_id, pad
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tuser,  // kind
    input  logic         s_axis_tlast,  // final_box
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_body, hit_distance, point_x, point_y, point_z, normal_axis,
    // normal_negative, pad
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tuser   // hit
);
    import rbh_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_ready, emit, in_fire;
    logic    r_ovalid;
    logic [OUT_DATA_W-1:0] dp_out;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = ctrl_ready;

    rbh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_kind    (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_ready   (ctrl_ready),
        .o_emit    (emit)
    );

    rbh_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  ({s_axis_tdata[254:0], s_axis_tuser}),
        .i_cmd   (cmd),
        .o_status(status),
        .o_data  (dp_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = dp_out[0];
    assign m_axis_tdata  = {6'b0, dp_out[OUT_DATA_W-1:1]};
endmodule

/* src/rbh_div.sv */
// ----------------------------------------------------------------------------
// rbh_div
// Restoring radix-2 signed divider, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module rbh_div #(
    parameter int unsigned NUM_W = 49,
    parameter int unsigned DEN_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_busy,
    output logic signed [NUM_W:0]   o_quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DEN_W+1:0] w_trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_q[NUM_W-1]} - {2'b00, r_den};
        if (i_start) begin
            n_q    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_den  = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            n_neg  = i_num[NUM_W-1] ^ i_den[DEN_W-1];
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DEN_W+1]) begin
                n_rem = w_trial[DEN_W:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
endmodule

/* src/rbh_datapath.sv */
// ----------------------------------------------------------------------------
// rbh_datapath
// Ray and box registers, slab arithmetic, best hit and hit point.
// ----------------------------------------------------------------------------
module rbh_datapath #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rbh_pkg::IN_DATA_W-1:0]       i_data,
    input  rbh_pkg::t_cmd                       i_cmd,
    output rbh_pkg::t_status                    o_status,
    output logic [rbh_pkg::OUT_DATA_W-1:0]      o_data
);
    import rbh_pkg::*;

    localparam int unsigned NUM_W = 33 + FRACTION_BITS;
    localparam logic [31:0] DIR_EPS =
        32'(((64'd1 << FRACTION_BITS) + 64'd999999) / 64'd1000000);

    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_lo  [3];
    logic signed [31:0] r_hi  [3];
    logic [30:0]        r_range;
    logic [31:0]        r_body;
    logic               r_best_valid;
    logic [31:0]        r_best_body;
    logic [30:0]        r_best_dist;
    logic [2:0]         r_best_norm;
    logic signed [NUM_W:0] r_t1;
    logic signed [NUM_W+1:0] r_tmin, r_tmax;
    logic [2:0]         r_norm;
    logic signed [31:0] r_pt [3];
    logic signed [63:0] r_prod;
    logic [OUT_DATA_W-1:0] r_out;

    logic signed [31:0] w_o, w_d, w_lo, w_hi;
    logic [31:0]        w_ad;
    logic signed [32:0] w_diff;
    logic signed [NUM_W-1:0] w_num;
    logic                 div_busy;
    logic signed [NUM_W:0] div_q;
    logic signed [NUM_W:0] w_tsmall, w_tlarge;
    logic signed [NUM_W+1:0] w_nmin, w_nmax;
    logic signed [63:0] w_fl;
    logic signed [64:0] w_sum;
    logic signed [31:0] w_sat;

    assign w_o  = r_org[i_cmd.axis];
    assign w_d  = r_dir[i_cmd.axis];
    assign w_lo = r_lo[i_cmd.axis];
    assign w_hi = r_hi[i_cmd.axis];
    assign w_ad = w_d[31] ? 32'(-w_d) : 32'(w_d);
    assign w_diff = (i_cmd.div_second ? 33'(w_hi) : 33'(w_lo)) - 33'(w_o);
    assign w_num  = {w_diff, {FRACTION_BITS{1'b0}}};

    rbh_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_d),
        .o_busy (div_busy),
        .o_quot (div_q)
    );

    always_comb begin
        w_tsmall = (r_t1 > div_q) ? div_q : r_t1;
        w_tlarge = (r_t1 > div_q) ? r_t1 : div_q;
        w_nmin   = (NUM_W+2)'(w_tsmall) > r_tmin ? (NUM_W+2)'(w_tsmall) : r_tmin;
        w_nmax   = (NUM_W+2)'(w_tlarge) < r_tmax ? (NUM_W+2)'(w_tlarge) : r_tmax;
    end

    // Floor of the product, then add and saturate.
    assign w_fl  = r_prod >>> FRACTION_BITS;
    assign w_sum = 65'(w_o) + 65'(w_fl);
    assign w_sat = (w_sum > 65'sd2147483647) ? 32'sh7fffffff :
                   (w_sum < -65'sd2147483648) ? 32'sh80000000 : 32'(w_sum);

    assign o_status.div_busy  = div_busy;
    assign o_status.axis_skip = (w_ad < DIR_EPS);
    assign o_status.axis_miss = (w_o < w_lo) || (w_o > w_hi);
    assign o_status.slab_miss = r_tmin > r_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
            r_range      <= '0;
            r_best_valid <= 1'b0;
            r_best_body  <= '0;
            r_best_dist  <= '0;
            r_best_norm  <= '0;
        end else begin
            if (i_cmd.load_ray) begin
                for (int i = 0; i < 3; i++) begin
                    r_org[i] <= i_data[1+32*i +: 32];
                    r_dir[i] <= i_data[97+32*i +: 32];
                end
                r_range      <= i_data[193 +: 31];
                r_best_valid <= 1'b0;
            end
            if (i_cmd.box_finish && !(r_tmin > r_tmax) &&
                (!r_best_valid || r_tmin[30:0] < r_best_dist)) begin
                r_best_valid <= 1'b1;
                r_best_body  <= r_body;
                r_best_dist  <= r_tmin[30:0];
                r_best_norm  <= r_norm;
            end
            if (i_cmd.emit) r_best_valid <= 1'b0;
        end
        if (i_cmd.load_box) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= i_data[1+32*i +: 32];
                r_hi[i] <= i_data[97+32*i +: 32];
            end
            r_body <= i_data[224 +: 32 - 24 + 24];
            r_tmin <= '0;
            r_tmax <= (NUM_W+2)'({1'b0, r_range});
            r_norm <= '0;
        end
        if (i_cmd.div_start && i_cmd.div_second) r_t1 <= div_q;
        if (i_cmd.axis_finish) begin
            r_tmax <= w_nmax;
            if ((NUM_W+2)'(w_tsmall) > r_tmin) begin
                r_tmin <= w_nmin;
                r_norm <= {~w_d[31], i_cmd.axis + 2'd1};
            end
        end
        if (i_cmd.mul_start) r_prod <= w_d * $signed({1'b0, r_best_dist});
        if (i_cmd.mul_store) r_pt[i_cmd.axis] <= w_sat;
        if (i_cmd.emit) begin
            r_out <= r_best_valid ?
                {r_best_norm[1:0] != 2'd0 ? r_best_norm[2] : 1'b0, r_best_norm[1:0],
                 r_pt[2], r_pt[1], r_pt[0], r_best_dist, r_best_body, 1'b1} : '0;
        end
    end

    assign o_data = r_out;
endmodule

/* src/rbh_ctrl.sv */
// ----------------------------------------------------------------------------
// rbh_ctrl
// Sequencer: two divisions per axis with a nonzero direction, then best hit update and, for a final box, hit point.
// ----------------------------------------------------------------------------
module rbh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_kind,
    input  logic             i_last,
    input  logic             i_out_free,
    input  rbh_pkg::t_status i_status,
    output rbh_pkg::t_cmd    o_cmd,
    output logic             o_ready,
    output logic             o_emit
);
    import rbh_pkg::*;
    `include "ray_box_nearest_hit_core_macros.svh"

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_AXIS  = 10'b0000000010,
        S_DIV1  = 10'b0000000100,
        S_DIV2  = 10'b0000001000,
        S_FOLD  = 10'b0000010000,
        S_BEST  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_STORE = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_last, n_last;
    logic       r_dead, n_dead;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_last  = r_last;
        n_dead  = r_dead;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        o_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    if (!i_kind) begin
                        o_cmd.load_ray = 1'b1;
                    end else begin
                        o_cmd.load_box = 1'b1;
                        n_last  = i_last;
                        n_axis  = 2'd0;
                        n_dead  = 1'b0;
                        n_state = S_AXIS;
                    end
                end
            end
            S_AXIS: begin
                if (r_axis == 2'd3 || r_dead) begin
                    n_state = S_BEST;
                end else if (i_status.axis_skip) begin
                    if (i_status.axis_miss) n_dead = 1'b1;
                    n_axis = r_axis + 2'd1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (!i_status.div_busy) begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_second = 1'b1;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!i_status.div_busy) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.axis_finish = 1'b1;
                n_axis  = r_axis + 2'd1;
                n_state = S_AXIS;
            end
            S_BEST: begin
                if (!r_dead && i_status.slab_miss) n_dead = 1'b1;
                o_cmd.box_finish = !r_dead;
                n_axis  = 2'd1;
                n_state = r_last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.axis      = r_axis - 2'd1;
                o_cmd.mul_start = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.axis      = r_axis - 2'd1;
                o_cmd.mul_store = 1'b1;
                n_axis  = r_axis + 2'd1;
                n_state = (r_axis == 2'd3) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_last  <= 1'b0;
            r_dead  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_last  <= n_last;
            r_dead  <= n_dead;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    `RBH_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, o_emit, i_out_free,
                     "emit while output register is full")
    `RBH_ASSERT_NEXT(a_box_starts, i_clk, i_rst_n, i_in_fire && i_kind, r_state == S_AXIS,
                     "box transaction did not start the axis loop")
    `RBH_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, i_in_fire, r_state == S_IDLE,
                     "transaction accepted while busy")
endmodule

/* bench/ray_box_nearest_hit_checker.sv */
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_checker
// Watches both streams of the ray / box nearest hit block, predicts each
// query result from the accepted transactions and compares field by field.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [255:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [167:0] i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_results,
    output int           o_hits
);
    localparam int FRAC = 16;

    typedef struct {
        logic        hit;
        logic [31:0] body;
        logic [30:0] hit_dist;
        logic [31:0] px, py, pz;
        logic [1:0]  axis;
        logic        neg;
    } t_hit_report;

    t_hit_report hit_queue[$];

    longint ray_org[3];
    longint ray_dir[3];
    longint ray_rng;
    bit         best_ok;
    logic [31:0] best_id;
    longint     best_t;
    logic [1:0] best_axis;
    logic       best_neg;

    // Field layout of the result, lowest bit first.
    function automatic t_hit_report unpack_report(logic [167:0] v, logic hit);
        t_hit_report r;
        r.hit      = hit;
        r.body     = v[31:0];
        r.hit_dist = v[62:32];
        r.px       = v[94:63];
        r.py       = v[126:95];
        r.pz       = v[158:127];
        r.axis     = v[160:159];
        r.neg      = v[161];
        return r;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic box_query(logic [255:0] d, logic last);
        longint lo[3], hi[3], tmin, tmax, t1, t2, s, dd;
        logic [1:0] ax;
        logic ng;
        bit miss;
        logic [31:0] id;
        logic [167:0] pk;
        longint p;
        t_hit_report r;
        for (int i = 0; i < 3; i++) begin
            lo[i] = longint'($signed(d[32*i +: 32]));
            hi[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        id = d[254:223];
        tmin = 0;
        tmax = ray_rng;
        ax = 2'd0;
        ng = 1'b0;
        miss = 0;
        for (int i = 0; i < 3 && !miss; i++) begin
            dd = ray_dir[i];
            if (dd == 0) begin
                if (ray_org[i] < lo[i] || ray_org[i] > hi[i]) miss = 1;
            end else begin
                t1 = ((lo[i] - ray_org[i]) * (64'sd1 <<< FRAC)) / dd;
                t2 = ((hi[i] - ray_org[i]) * (64'sd1 <<< FRAC)) / dd;
                if (t1 > t2) begin
                    s = t1; t1 = t2; t2 = s;
                end
                if (t1 > tmin) begin
                    tmin = t1;
                    ax = 2'(i + 1);
                    ng = (dd > 0);
                end
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) miss = 1;
            end
        end
        if (!miss && (!best_ok || tmin < best_t)) begin
            best_ok = 1;
            best_id = id;
            best_t = tmin;
            best_axis = ax;
            best_neg = ng;
        end
        if (!last) return;
        pk = '0;
        if (best_ok) begin
            pk[31:0]  = best_id;
            pk[62:32] = 31'(best_t);
            for (int i = 0; i < 3; i++) begin
                p = ray_dir[i] * best_t;
                pk[63 + 32*i +: 32] = 32'(sat32(ray_org[i] + (p >>> FRAC)));
            end
            pk[160:159] = best_axis;
            pk[161] = (best_axis != 2'd0) ? best_neg : 1'b0;
        end
        r = unpack_report(pk, best_ok);
        hit_queue.insert(hit_queue.size(), r);
        best_ok = 0; best_id = '0; best_t = 0; best_axis = '0; best_neg = 0;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_hits = 0;
        for (int i = 0; i < 3; i++) begin
            ray_org[i] = 0;
            ray_dir[i] = 0;
        end
        ray_rng = 0;
        best_ok = 0; best_id = '0; best_t = 0; best_axis = '0; best_neg = 0;
    end

    always @(posedge i_clk) begin
        t_hit_report got, want;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            if (i_s_tuser == 1'b0) begin
                for (int i = 0; i < 3; i++) begin
                    ray_org[i] = longint'($signed(i_s_tdata[32*i +: 32]));
                    ray_dir[i] = longint'($signed(i_s_tdata[96 + 32*i +: 32]));
                end
                ray_rng = longint'(i_s_tdata[222:192]);
                best_ok = 0; best_id = '0; best_t = 0; best_axis = '0; best_neg = 0;
            end else begin
                box_query(i_s_tdata, i_s_tlast);
            end
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got = unpack_report(i_m_tdata, i_m_tuser);
            o_results = o_results + 1;
            if (hit_queue.size() == 0) begin
                $error("result transaction with nothing expected");
                o_errors = o_errors + 1;
            end else begin
                want = hit_queue.pop_front();
                if (want.hit) o_hits = o_hits + 1;
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    o_errors = o_errors + 1;
                end
                if (got.body !== want.body) begin
                    $error("hit_body: expected %0h, got %0h", want.body, got.body);
                    o_errors = o_errors + 1;
                end
                if (got.hit_dist !== want.hit_dist) begin
                    $error("hit_distance: expected %0h, got %0h",
                           want.hit_dist, got.hit_dist);
                    o_errors = o_errors + 1;
                end
                if (got.px !== want.px) begin
                    $error("point_x: expected %0h, got %0h", want.px, got.px);
                    o_errors = o_errors + 1;
                end
                if (got.py !== want.py) begin
                    $error("point_y: expected %0h, got %0h", want.py, got.py);
                    o_errors = o_errors + 1;
                end
                if (got.pz !== want.pz) begin
                    $error("point_z: expected %0h, got %0h", want.pz, got.pz);
                    o_errors = o_errors + 1;
                end
                if (got.axis !== want.axis) begin
                    $error("normal_axis: expected %0d, got %0d", want.axis, got.axis);
                    o_errors = o_errors + 1;
                end
                if (got.neg !== want.neg) begin
                    $error("normal_negative: expected %0d, got %0d", want.neg, got.neg);
                    o_errors = o_errors + 1;
                end
            end
        end
        o_pending = hit_queue.size();
    end
endmodule

/* bench/tb_ray_box_nearest_hit_core.sv */
// ----------------------------------------------------------------------------
// tb_ray_box_nearest_hit_core
// Drives rays and boxes into the nearest hit block with random gaps and
// output stalls; the checker predicts and compares every query result.
// ----------------------------------------------------------------------------
module tb_ray_box_nearest_hit_core;
    localparam int     ONE = 65536;
    localparam longint CYCLE_LIMIT = 3000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tuser;

    int     errors, pending, results, hits;
    int     items_sent;
    longint cycles;
    bit     quiet;
    int     stall_left;

    ray_box_nearest_hit_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    ray_box_nearest_hit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_hits(hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: draw a stall for every result transaction taken outside quiet mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left <= $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end
        end else if (stall_left > 0 && !quiet) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send(logic kind, logic [31:0] a[3], logic [31:0] b[3],
                        logic [30:0] lim, logic [31:0] id, logic last);
        int gap;
        logic [255:0] pk;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pk = {1'b0, id, lim, b[2], b[1], b[0], a[2], a[1], a[0]};
        s_axis_tdata  <= pk;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return ONE;
            2: return -ONE;
            3: return $urandom_range(1, ONE);
            4: return -$urandom_range(1, ONE);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_near();
        return $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
    endfunction

    task automatic send_ray(logic [31:0] o[3], logic [31:0] d[3], logic [30:0] lim);
        send(1'b0, o, d, lim, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_box(logic [31:0] lo[3], logic [31:0] hi[3], logic [31:0] id,
                            logic last);
        send(1'b1, lo, hi, 31'($urandom), id, last);
    endtask

    task automatic rand_box(logic last);
        logic [31:0] lo[3], hi[3];
        int shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (shape == 0) begin
                lo[i] = $urandom;
                hi[i] = $urandom;
            end else begin
                lo[i] = rand_near();
                hi[i] = lo[i] + $urandom_range(0, 15 * ONE);
                if (shape == 1) begin
                    hi[i] = lo[i];
                    lo[i] = lo[i] + ONE;
                end
            end
        end
        send_box(lo, hi, $urandom, last);
    endtask

    initial begin
        logic [31:0] o[3], d[3], lo[3], hi[3];
        int nbox;
        cycles = 0;
        items_sent = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // box before any ray: tested against the all-zero ray
        lo = '{-ONE, -ONE, -ONE}; hi = '{ONE, ONE, ONE};
        send_box(lo, hi, 32'hFFFF_FFFF, 1'b1);
        lo = '{ONE, 0, 0}; hi = '{2 * ONE, ONE, ONE};
        send_box(lo, hi, 32'h1, 1'b1);
        // axis-aligned rays with each sign, a hit on one face per axis
        for (int ax = 0; ax < 3; ax++) begin
            o = '{0, 0, 0}; d = '{0, 0, 0};
            d[ax] = (ax == 1) ? -ONE : ONE;
            send_ray(o, d, 31'h7FFF_FFFF);
            lo = '{-ONE, -ONE, -ONE}; hi = '{ONE, ONE, ONE};
            lo[ax] = (ax == 1) ? -6 * ONE : 3 * ONE;
            hi[ax] = lo[ax] + 2 * ONE;
            send_box(lo, hi, 32'hAAAA_5555, 1'b0);
            lo[ax] = (ax == 1) ? -4 * ONE : 2 * ONE;
            send_box(lo, hi, 32'h5555_AAAA, 1'b0);
            // origin inside: distance 0, no normal
            lo = '{-ONE, -ONE, -ONE}; hi = '{ONE, ONE, ONE};
            send_box(lo, hi, 32'h0000_0007, 1'b1);
        end
        // a miss past the range, then an inverted box on a zero-direction axis
        o = '{32'h8000_0000, 32'h7FFF_FFFF, 0}; d = '{0, 0, ONE};
        send_ray(o, d, 31'd0);
        lo = '{32'h8000_0000, 32'h7FFF_FFFF, ONE}; hi = lo;
        send_box(lo, hi, 32'd9, 1'b0);
        lo = '{32'h7FFF_FFFF, 32'h8000_0000, -ONE}; hi = '{32'h8000_0000, 32'h7FFF_FFFF, ONE};
        send_box(lo, hi, 32'd10, 1'b1);
        // extreme directions, saturated hit point
        o = '{32'h7FFF_0000, 32'h8000_0000, 0};
        d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        send_ray(o, d, 31'h7FFF_FFFF);
        lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_box(lo, hi, 32'h8000_0001, 1'b1);
        // repeat query on the same ray after the best hit was cleared
        send_box(lo, hi, 32'h0F0F_0F0F, 1'b1);

        while (items_sent < 620) begin
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: fully random transaction
                for (int i = 0; i < 3; i++) begin
                    lo[i] = $urandom; hi[i] = $urandom;
                end
                send(1'($urandom_range(0, 1)), lo, hi, 31'($urandom), $urandom,
                     1'($urandom_range(0, 1)));
            end else begin
                for (int i = 0; i < 3; i++) begin
                    o[i] = ($urandom_range(0, 15) == 0) ? $urandom : rand_near();
                    d[i] = rand_dir();
                end
                send_ray(o, d, 31'(($urandom_range(0, 3) == 0) ?
                                   $urandom : $urandom_range(0, 60 * ONE)));
                nbox = $urandom_range(1, 4);
                for (int k = 0; k < nbox; k++)
                    rand_box((k == nbox - 1) && ($urandom_range(0, 11) != 0));
            end
        end
        s_axis_tvalid <= 1'b0;
        quiet = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("%0d transactions sent, %0d query results checked, %0d of them hits",
                 items_sent, results, hits);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
